>>> rtl/core/mi4_pkg.sv
package mi4_pkg;

    localparam int DIM   = 4;
    localparam int ELEMS = 16;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_MUL1,
        ST_MUL2,
        ST_ACC,
        ST_COF,
        ST_DET,
        ST_DETACC,
        ST_CHECK,
        ST_DIV,
        ST_EMIT
    } t_state;

    // 3x3 permutation order of the minor's columns: (012)(120)(201)(021)(210)(102)
    function automatic logic [1:0] perm_col(input logic [2:0] t, input logic [1:0] pos);
        logic [5:0] row;
        begin
            case (t)
                3'd0:    row = {2'd2, 2'd1, 2'd0};
                3'd1:    row = {2'd0, 2'd2, 2'd1};
                3'd2:    row = {2'd1, 2'd0, 2'd2};
                3'd3:    row = {2'd1, 2'd2, 2'd0};
                3'd4:    row = {2'd0, 2'd1, 2'd2};
                default: row = {2'd2, 2'd0, 2'd1};
            endcase
            perm_col = row[pos*2 +: 2];
        end
    endfunction

    // the k-th index of {0..3} with skip removed
    function automatic logic [1:0] skip_idx(input logic [1:0] skip, input logic [1:0] k);
        begin
            skip_idx = (k >= skip) ? 2'(k + 2'd1) : k;
        end
    endfunction

    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
        logic signed [64:0] s;
        begin
            s = {a[63], a} + {b[63], b};
            if (s[64] != s[63])
                sat_add64 = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
            else
                sat_add64 = s[63:0];
        end
    endfunction

    function automatic logic signed [63:0] sat_neg64(input logic signed [63:0] a);
        begin
            sat_neg64 = (a == {1'b1, 63'd0}) ? {1'b0, {63{1'b1}}} : -a;
        end
    endfunction

endpackage

>>> rtl/core/mi4_mul.sv
module mi4_mul
    import mi4_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_a,
    input  logic signed [63:0] i_b,
    output logic               o_done,
    output logic signed [63:0] o_p
);

    // 64x64 magnitude product as four 32x32 partial products, one per cycle
    logic [63:0]  r_ma, r_mb;
    logic         r_neg;
    logic [127:0] r_acc;
    logic [2:0]   r_step;
    logic         r_run;
    logic         r_done;
    logic signed [63:0] r_p;

    logic [31:0]  w_x, w_y;
    logic [63:0]  w_pp;
    logic [127:0] w_sh;
    logic [127:0] w_sum;
    logic [127:0] w_rnd;
    logic [127:0] w_q;
    logic [63:0]  w_lim;
    logic [63:0]  w_mag;

    always_comb begin
        w_x = r_step[0] ? r_ma[63:32] : r_ma[31:0];
        w_y = r_step[1] ? r_mb[63:32] : r_mb[31:0];
        w_pp = 64'(w_x) * 64'(w_y);
        w_sh = 128'(w_pp) << (32 * (32'(r_step[0]) + 32'(r_step[1])));
        w_sum = r_acc + w_sh;
        w_rnd = r_acc + (128'd1 << (FRAC_BITS - 1));
        w_q = w_rnd >> FRAC_BITS;
        w_lim = r_neg ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        w_mag = (w_q[127:64] != 64'd0 || w_q[63:0] > w_lim) ? w_lim : w_q[63:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_ma   <= i_a[63] ? 64'(-i_a) : i_a;
                r_mb   <= i_b[63] ? 64'(-i_b) : i_b;
                r_neg  <= i_a[63] ^ i_b[63];
                r_acc  <= '0;
                r_step <= '0;
                r_run  <= 1'b1;
            end else if (r_run) begin
                if (r_step == 3'd4) begin
                    r_p    <= r_neg ? -w_mag : w_mag;
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_acc  <= w_sum;
                    r_step <= r_step + 3'd1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_p    = r_p;

endmodule

>>> rtl/core/mi4_div.sv
module mi4_div
    import mi4_pkg::*;
#(
    parameter int VALUE_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [63:0]            i_num,
    input  logic signed [63:0]            i_den,
    output logic                          o_done,
    output logic signed [VALUE_WIDTH-1:0] o_q
);

    // restoring divide, one quotient bit per cycle over 128 dividend bits
    logic [127:0] r_n;
    logic [64:0]  r_rem;
    logic [127:0] r_q;
    logic [63:0]  r_d;
    logic         r_neg;
    logic [7:0]   r_cnt;
    logic         r_run;
    logic         r_fin;
    logic         r_done;
    logic signed [VALUE_WIDTH-1:0] r_out;

    logic [64:0]  w_rem;
    logic [64:0]  w_sub;
    logic [64:0]  w_half;
    logic [127:0] w_qr;
    logic [63:0]  w_lim;
    logic [63:0]  w_mag;
    logic [63:0]  w_mn;

    always_comb begin
        w_rem  = {r_rem[63:0], r_n[127]};
        w_sub  = w_rem - {1'b0, r_d};
        w_half = {1'b0, r_d} - r_rem;
        w_qr   = (r_rem >= w_half) ? r_q + 128'd1 : r_q;
        w_lim  = (64'd1 << (VALUE_WIDTH - 1)) - (r_neg ? 64'd0 : 64'd1);
        w_mag  = (w_qr[127:64] != 64'd0 || w_qr[63:0] > w_lim) ? w_lim : w_qr[63:0];
        w_mn   = i_num[63] ? 64'(-i_num) : i_num;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            r_fin  <= 1'b0;
            if (i_start) begin
                r_n   <= {64'd0, w_mn} << (2 * FRAC_BITS);
                r_d   <= i_den[63] ? 64'(-i_den) : i_den;
                r_neg <= i_num[63] ^ i_den[63];
                r_rem <= '0;
                r_q   <= '0;
                r_cnt <= '0;
                r_run <= 1'b1;
            end else if (r_run) begin
                r_n <= r_n << 1;
                if (!w_sub[64]) begin
                    r_rem <= w_sub;
                    r_q   <= {r_q[126:0], 1'b1};
                end else begin
                    r_rem <= w_rem;
                    r_q   <= {r_q[126:0], 1'b0};
                end
                r_cnt <= r_cnt + 8'd1;
                if (r_cnt == 8'd127) begin
                    r_run <= 1'b0;
                    r_fin <= 1'b1;
                end
            end else if (r_fin) begin
                r_out  <= VALUE_WIDTH'(r_neg ? -w_mag : w_mag);
                r_done <= 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_q    = r_out;

endmodule

>>> rtl/core/matrix_inverse_4x4.sv
// 4x4 matrix inverse by cofactors and adjugate, signed fixed point.
// Input: raise start with one element on i_in_value; the item is taken at a
// rising edge with start high and busy low. Sixteen elements, row-major, make
// one matrix; busy stays low while loading.
// After the sixteenth element busy rises and the block forms 96 triple
// products and the determinant on one shared 64x64 multiplier (four 32x32
// partial products plus rounding per multiply), then 16 quotients on one
// bit-serial restoring divider; a singular matrix skips the divider. busy
// falls the cycle after the last result.
// Results: o_out_strobe marks each of the 16 inverse elements for one cycle,
// with o_out_index, o_singular and o_last_out. A zero determinant gives
// all-zero values with o_singular high. The receiver cannot stall the block.
// Reset (synchronous, active low) clears the load count and the sequencer.
module matrix_inverse_4x4
    import mi4_pkg::*;
#(
    parameter int VALUE_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [VALUE_WIDTH-1:0] i_in_value,
    output logic                          o_out_strobe,
    output logic signed [VALUE_WIDTH-1:0] o_out_value,
    output logic [3:0]                    o_out_index,
    output logic                          o_singular,
    output logic                          o_last_out
);

    logic signed [63:0] r_mat [ELEMS];
    logic signed [63:0] r_cof [ELEMS];
    logic [3:0]         r_cnt;
    t_state             r_state, n_state;
    logic [3:0]         r_cell;
    logic [2:0]         r_term;
    logic signed [63:0] r_acc;
    logic signed [63:0] r_pair;
    logic signed [63:0] r_det;
    logic               r_sing;
    logic               r_wait;

    logic [1:0] w_r, w_c, w_row0, w_row1, w_row2;
    logic [1:0] w_c0, w_c1, w_c2;
    logic signed [63:0] w_e0, w_e1, w_e2;
    logic signed [63:0] w_p;
    logic               w_mdone;
    logic               w_ddone;
    logic signed [VALUE_WIDTH-1:0] w_q;
    logic               w_mstart, w_dstart;
    logic signed [63:0] w_ma, w_mb;
    logic [3:0]         w_tidx;

    assign w_r    = r_cell[3:2];
    assign w_c    = r_cell[1:0];
    assign w_row0 = skip_idx(w_r, 2'd0);
    assign w_row1 = skip_idx(w_r, 2'd1);
    assign w_row2 = skip_idx(w_r, 2'd2);
    assign w_c0   = skip_idx(w_c, perm_col(r_term, 2'd0));
    assign w_c1   = skip_idx(w_c, perm_col(r_term, 2'd1));
    assign w_c2   = skip_idx(w_c, perm_col(r_term, 2'd2));
    assign w_e0   = r_mat[{w_row0, w_c0}];
    assign w_e1   = r_mat[{w_row1, w_c1}];
    assign w_e2   = r_mat[{w_row2, w_c2}];
    assign w_tidx = {r_cell[1:0], r_cell[3:2]};

    // MUL2 multiplies the pair product by the third element
    always_comb begin
        w_ma     = w_e0;
        w_mb     = w_e1;
        w_mstart = !r_wait && (r_state == ST_MUL1 || r_state == ST_MUL2
                               || r_state == ST_DET);
        w_dstart = !r_wait && !r_sing && r_state == ST_DIV;
        unique case (r_state)
            ST_MUL2: begin
                w_ma = r_pair;
                w_mb = w_e2;
            end
            ST_DET: begin
                w_ma = r_mat[{2'd0, r_cell[1:0]}];
                w_mb = r_cof[{2'd0, r_cell[1:0]}];
            end
            default: begin
                w_ma = w_e0;
                w_mb = w_e1;
            end
        endcase
    end

    mi4_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mstart),
        .i_a     (w_ma),
        .i_b     (w_mb),
        .o_done  (w_mdone),
        .o_p     (w_p)
    );

    mi4_div #(.VALUE_WIDTH(VALUE_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dstart),
        .i_num   (r_cof[w_tidx]),
        .i_den   (r_det),
        .o_done  (w_ddone),
        .o_q     (w_q)
    );

    // sequencer: r_pair holds the pair, then triple product; r_acc the minor sum, then the determinant
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD:   if (start && r_cnt == 4'd15) n_state = ST_MUL1;
            ST_MUL1:   if (w_mdone) n_state = ST_MUL2;
            ST_MUL2:   if (w_mdone) n_state = ST_ACC;
            ST_ACC:    n_state = (r_term == 3'd5) ? ST_COF : ST_MUL1;
            ST_COF:    n_state = (r_cell == 4'd15) ? ST_DET : ST_MUL1;
            ST_DET:    if (w_mdone) n_state = ST_DETACC;
            ST_DETACC: n_state = (r_cell[1:0] == 2'd3) ? ST_CHECK : ST_DET;
            ST_CHECK:  n_state = ST_DIV;
            ST_DIV:    if (r_sing || w_ddone) n_state = ST_EMIT;
            ST_EMIT:   n_state = (r_cell == 4'd15) ? ST_LOAD : ST_DIV;
            default:   n_state = ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_cnt   <= '0;
            r_cell  <= '0;
            r_term  <= '0;
            r_wait  <= 1'b0;
            o_out_strobe <= 1'b0;
        end else begin
            r_state      <= n_state;
            o_out_strobe <= 1'b0;
            if (w_mstart || w_dstart)
                r_wait <= 1'b1;
            if (w_mdone || w_ddone)
                r_wait <= 1'b0;
            unique case (r_state)
                ST_LOAD: begin
                    if (start) begin
                        r_mat[r_cnt] <= 64'(i_in_value);
                        r_cnt <= r_cnt + 4'd1;
                        r_cell <= '0;
                        r_term <= '0;
                        r_acc  <= '0;
                    end
                end
                ST_MUL1: if (w_mdone) r_pair <= w_p;
                ST_MUL2: if (w_mdone) r_pair <= w_p;
                ST_ACC: begin
                    r_acc  <= sat_add64(r_acc, (r_term < 3'd3) ? r_pair : sat_neg64(r_pair));
                    r_term <= (r_term == 3'd5) ? 3'd0 : r_term + 3'd1;
                end
                ST_COF: begin
                    r_cof[r_cell] <= (w_r[0] ^ w_c[0]) ? sat_neg64(r_acc) : r_acc;
                    r_acc  <= '0;
                    r_cell <= r_cell + 4'd1;
                end
                ST_DET: if (w_mdone) r_pair <= w_p;
                ST_DETACC: begin
                    r_acc  <= sat_add64(r_acc, r_pair);
                    r_cell <= r_cell + 4'd1;
                end
                ST_CHECK: begin
                    r_det  <= r_acc;
                    r_sing <= (r_acc == 64'sd0);
                    r_cell <= '0;
                end
                ST_DIV: begin
                    if (r_sing || w_ddone) begin
                        o_out_value <= r_sing ? '0 : w_q;
                        o_out_index <= r_cell;
                        o_singular  <= r_sing;
                        o_last_out  <= (r_cell == 4'd15);
                        o_out_strobe <= 1'b1;
                    end
                end
                ST_EMIT: r_cell <= r_cell + 4'd1;
                default: ;
            endcase
        end
    end

    always_comb begin
        busy = (r_state != ST_LOAD);
    end

endmodule
